// File: rtl/core/ufbs_pkg.sv
package ufbs_pkg;

  localparam int CLK_W  = 27;
  localparam int BAUD_W = 24;
  localparam int DL_W   = 16;
  localparam int FD_W   = 4;
  localparam int WORD_W = 32;
  // divisors stay below 2^29 for every candidate
  localparam int DEN_W  = 29;
  localparam int SUM_W  = 5;
  localparam int CNT_W  = 5;

  localparam logic [CLK_W-1:0] CLK_RESET = 27'd100000000;
  localparam logic [FD_W-1:0]  MUL_LAST  = 4'd15;
  localparam logic [FD_W-1:0]  DADD_LAST = 4'd14;

endpackage

// File: rtl/core/uart_fractional_baud_search_unit.sv
// uart fractional baud divider search
//
// configuration: the peripheral clock in hertz is written through the
// cfg_valid / cfg_ready / cfg_data channel, only while the unit is idle.
// cfg_ready is high whenever busy is low. reset loads 100 MHz.
//
// operation: an item (baud_rate) is taken at a clock edge with start high
// and busy low. busy stays high until the result has been shown. the result
// (divisor_latch, mul_val, div_add_val) is on the outputs for exactly one
// cycle with result_valid high; the receiver cannot stall it.
//
// search: one restoring divider, one quotient bit per cycle, does all the
// work. an exact clock / (16 * baud) needs only the first division. otherwise
// each of the 120 multiplier / divide-add pairs needs two divisions, each
// followed by a bookkeeping state. a zero baud rate skips the divider and
// goes straight to the result. one item is in flight at a time.
//
// reset: synchronous, active high; returns to idle and restores the clock.
module uart_fractional_baud_search_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ufbs_pkg::BAUD_W-1:0]     baud_rate,
  output logic                            result_valid,
  output logic [ufbs_pkg::DL_W-1:0]       divisor_latch,
  output logic [ufbs_pkg::FD_W-1:0]       mul_val,
  output logic [ufbs_pkg::FD_W-1:0]       div_add_val,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ufbs_pkg::CLK_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DIVIDE    = 3'd1;
  localparam logic [2:0] ST_POST_INIT = 3'd2;
  localparam logic [2:0] ST_POST_LAT  = 3'd3;
  localparam logic [2:0] ST_POST_RATE = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  localparam int W  = ufbs_pkg::WORD_W;
  localparam int DW = ufbs_pkg::DEN_W;

  logic [2:0]                    state, state_next;
  logic [2:0]                    ret_state, ret_state_next;
  logic [ufbs_pkg::CLK_W-1:0]    clk_reg;
  logic [ufbs_pkg::BAUD_W-1:0]   baud_reg;
  logic [ufbs_pkg::FD_W-1:0]     mv, mv_next;
  logic [ufbs_pkg::FD_W-1:0]     dav, dav_next;
  logic                          lat_sel, lat_sel_next;
  logic [ufbs_pkg::DL_W-1:0]     dlv, dlv_next;
  logic [ufbs_pkg::DL_W-1:0]     best_dl, best_dl_next;
  logic [ufbs_pkg::FD_W-1:0]     best_mul, best_mul_next;
  logic [ufbs_pkg::FD_W-1:0]     best_dav, best_dav_next;
  logic [ufbs_pkg::BAUD_W-1:0]   least_err, least_err_next;

  // shared restoring divider
  logic [W-1:0]                  rem, quo;
  logic [DW-1:0]                 dvs;
  logic [ufbs_pkg::CNT_W-1:0]    cnt;
  logic [W:0]                    rem_sh;
  logic                          rem_ge;
  logic                          div_load;
  logic [W-1:0]                  div_num;
  logic [DW-1:0]                 div_den;

  // candidate arithmetic
  logic                          accept;
  logic [ufbs_pkg::FD_W-1:0]     cand_mv, cand_dav;
  logic [ufbs_pkg::SUM_W-1:0]    cand_sum, cur_sum;
  logic [W-1:0]                  lat_prod, lat_p2;
  logic [W-1:0]                  lat_num;
  logic [DW-1:0]                 lat_den;
  logic [W-1:0]                  q_shift, q_round;
  logic [ufbs_pkg::DL_W-1:0]     dl_forced;
  logic [W-1:0]                  rate_num;
  logic [DW-1:0]                 rate_den;
  logic [W-1:0]                  rate, err;
  logic                          last_pair;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  assign result_valid  = (state == ST_DONE);
  assign divisor_latch = best_dl;
  assign mul_val       = best_mul;
  assign div_add_val   = best_dav;

  // one quotient bit per cycle
  assign rem_sh = {rem, quo[W-1]};
  assign rem_ge = (rem_sh >= {{(W+1-DW){1'b0}}, dvs});

  // pair to be tried next: after the current one, or the first one
  assign last_pair = (mv == ufbs_pkg::MUL_LAST) && (dav == ufbs_pkg::DADD_LAST);
  always_comb begin
    if (state == ST_POST_INIT) begin
      cand_mv  = 4'd1;
      cand_dav = 4'd0;
    end else if (dav == mv - 4'd1) begin
      cand_mv  = mv + 4'd1;
      cand_dav = 4'd0;
    end else begin
      cand_mv  = mv;
      cand_dav = dav + 4'd1;
    end
  end

  // latch division operands: keep the widest dividend that fits 32 bits
  assign cand_sum = {1'b0, cand_mv} + {1'b0, cand_dav};
  assign lat_prod = W'(cand_mv) * W'(clk_reg);
  assign lat_p2   = {lat_prod[W-2:0], 1'b0};
  assign lat_num  = lat_p2[W-1] ? lat_p2 : {lat_p2[W-2:0], 1'b0};
  assign lat_den  = DW'(baud_reg) * DW'(cand_sum);

  // rounded latch from the quotient, then the lower bounds
  assign q_shift = lat_sel ? (quo >> 4) : (quo >> 5);
  assign q_round = (q_shift + W'(1)) >> 1;
  always_comb begin
    dl_forced = q_round[ufbs_pkg::DL_W-1:0];
    if (dl_forced == '0) begin
      dl_forced = 16'd1;
    end
    if ((dav != '0) && (dl_forced < 16'd2)) begin
      dl_forced = 16'd2;
    end
  end

  // achieved rate division operands
  assign cur_sum  = {1'b0, mv} + {1'b0, dav};
  assign rate_num = W'(mv) * W'(clk_reg);
  assign rate_den = (DW'(dl_forced) * DW'(cur_sum)) << 3;

  assign rate = (quo + W'(1)) >> 1;
  assign err  = (rate >= W'(baud_reg)) ? (rate - W'(baud_reg)) : (W'(baud_reg) - rate);

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    mv_next        = mv;
    dav_next       = dav;
    lat_sel_next   = lat_sel;
    dlv_next       = dlv;
    best_dl_next   = best_dl;
    best_mul_next  = best_mul;
    best_dav_next  = best_dav;
    least_err_next = least_err;
    div_load       = 1'b0;
    div_num        = lat_num;
    div_den        = lat_den;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (baud_rate == '0) begin
            // slowest setting
            best_dl_next  = '1;
            best_mul_next = 4'd1;
            best_dav_next = 4'd0;
            state_next    = ST_DONE;
          end else begin
            div_load       = 1'b1;
            div_num        = W'(clk_reg);
            div_den        = DW'({baud_rate, 4'b0000});
            ret_state_next = ST_POST_INIT;
            state_next     = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (cnt == '1) begin
          state_next = ret_state;
        end
      end
      ST_POST_INIT: begin
        best_dl_next   = quo[ufbs_pkg::DL_W-1:0];
        best_mul_next  = 4'd1;
        best_dav_next  = 4'd0;
        least_err_next = baud_reg;
        if (rem != '0) begin
          // inexact: start the pair search
          mv_next        = cand_mv;
          dav_next       = cand_dav;
          lat_sel_next   = lat_p2[W-1];
          div_load       = 1'b1;
          ret_state_next = ST_POST_LAT;
          state_next     = ST_DIVIDE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_POST_LAT: begin
        dlv_next       = dl_forced;
        div_load       = 1'b1;
        div_num        = rate_num;
        div_den        = rate_den;
        ret_state_next = ST_POST_RATE;
        state_next     = ST_DIVIDE;
      end
      ST_POST_RATE: begin
        if (err < W'(least_err)) begin
          least_err_next = err[ufbs_pkg::BAUD_W-1:0];
          best_dl_next   = dlv;
          best_mul_next  = mv;
          best_dav_next  = dav;
        end
        if (last_pair) begin
          state_next = ST_DONE;
        end else begin
          mv_next        = cand_mv;
          dav_next       = cand_dav;
          lat_sel_next   = lat_p2[W-1];
          div_load       = 1'b1;
          ret_state_next = ST_POST_LAT;
          state_next     = ST_DIVIDE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      clk_reg   <= ufbs_pkg::CLK_RESET;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      if (cfg_valid && cfg_ready) begin
        clk_reg <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      baud_reg <= baud_rate;
    end
    mv        <= mv_next;
    dav       <= dav_next;
    lat_sel   <= lat_sel_next;
    dlv       <= dlv_next;
    best_dl   <= best_dl_next;
    best_mul  <= best_mul_next;
    best_dav  <= best_dav_next;
    least_err <= least_err_next;
    if (div_load) begin
      rem <= '0;
      quo <= div_num;
      dvs <= div_den;
      cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      if (rem_ge) begin
        rem <= W'(rem_sh - {{(W+1-DW){1'b0}}, dvs});
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: tb/sv/uart_fractional_baud_search_unit_test.sv
module uart_fractional_baud_search_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake of any kind before the run is declared hung,
  // well above the longest search
  localparam int QUIET_LIMIT = 40000;
  // cycles allowed after the last result before the final verdict
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 21;
  localparam int N_PHASES    = 4;
  localparam int N_ROWS      = 23;

  // one divider setting as the block reports it
  typedef struct packed {
    logic [ufbs_pkg::DL_W-1:0] dl;
    logic [ufbs_pkg::FD_W-1:0] mv;
    logic [ufbs_pkg::FD_W-1:0] dav;
  } divider_t;

  // a directed row either rewrites the clock register or sends one baud
  // rate; typed rows carry a setting that is plain from the definition
  typedef struct packed {
    bit                          wr_clock;
    logic [ufbs_pkg::CLK_W-1:0]  clock_hz;
    logic [ufbs_pkg::BAUD_W-1:0] baud;
    bit                          typed;
    divider_t                    fixed;
  } setup_row_t;

  localparam divider_t SLOWEST = '{16'hFFFF, 4'd1, 4'd0};
  localparam divider_t NONE    = '{16'd0, 4'd0, 4'd0};

  localparam setup_row_t SETUP_ROWS [N_ROWS] = '{
    // reset clock of 100 MHz
    '{1'b0, 27'd0, 24'd0,        1'b1, SLOWEST},                // zero baud rate
    '{1'b0, 27'd0, 24'd6250,     1'b1, '{16'd1000, 4'd1, 4'd0}}, // exact quotient
    '{1'b0, 27'd0, 24'd1,        1'b1, '{16'd24080, 4'd1, 4'd0}},// exact, latch wraps
    '{1'b0, 27'd0, 24'd115200,   1'b0, NONE},
    '{1'b0, 27'd0, 24'hFFFFFF,   1'b0, NONE},
    '{1'b0, 27'd0, 24'd9600,     1'b0, NONE},
    // largest clock: products wrap and the bit 31 rounding path is taken
    '{1'b1, 27'h7FFFFFF, 24'd0,  1'b0, NONE},
    '{1'b0, 27'd0, 24'd1,        1'b0, NONE},
    '{1'b0, 27'd0, 24'hFFFFFF,   1'b0, NONE},
    '{1'b0, 27'd0, 24'd115200,   1'b0, NONE},
    // zero clock: remainder is zero so the latch is zero
    '{1'b1, 27'd0, 24'd0,        1'b0, NONE},
    '{1'b0, 27'd0, 24'd9600,     1'b1, '{16'd0, 4'd1, 4'd0}},
    '{1'b0, 27'd0, 24'hFFFFFF,   1'b1, '{16'd0, 4'd1, 4'd0}},
    '{1'b0, 27'd0, 24'd0,        1'b1, SLOWEST},
    // smallest clock: no candidate beats the baud rate itself
    '{1'b1, 27'd1, 24'd0,        1'b0, NONE},
    '{1'b0, 27'd0, 24'd1,        1'b0, NONE},
    '{1'b0, 27'd0, 24'd0,        1'b1, SLOWEST},
    '{1'b1, 27'd16, 24'd0,       1'b0, NONE},
    '{1'b0, 27'd0, 24'd1,        1'b1, '{16'd1, 4'd1, 4'd0}},
    // classic uart crystal
    '{1'b1, 27'd1843200, 24'd0,  1'b0, NONE},
    '{1'b0, 27'd0, 24'd115200,   1'b1, '{16'd1, 4'd1, 4'd0}},
    '{1'b0, 27'd0, 24'd9600,     1'b1, '{16'd12, 4'd1, 4'd0}},
    '{1'b0, 27'd0, 24'd7,        1'b0, NONE}
  };

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        start     = 1'b0;
  logic                        busy;
  logic [ufbs_pkg::BAUD_W-1:0] baud_rate = '0;
  logic                        result_valid;
  logic [ufbs_pkg::DL_W-1:0]   divisor_latch;
  logic [ufbs_pkg::FD_W-1:0]   mul_val;
  logic [ufbs_pkg::FD_W-1:0]   div_add_val;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [ufbs_pkg::CLK_W-1:0]  cfg_data  = '0;

  uart_fractional_baud_search_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .baud_rate     (baud_rate),
    .result_valid  (result_valid),
    .divisor_latch (divisor_latch),
    .mul_val       (mul_val),
    .div_add_val   (div_add_val),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // shadow of the clock register, written only when the block takes a write
  logic [ufbs_pkg::CLK_W-1:0] clock_shadow = ufbs_pkg::CLK_RESET;
  divider_t         expected_settings [$];
  divider_t         oldest_setting;
  int               items_issued  = 0;
  int               results_done  = 0;
  int               error_count   = 0;
  int               quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // divider search in plain 32-bit unsigned arithmetic, wrapping as it goes
  function automatic divider_t search_divider(input logic [ufbs_pkg::CLK_W-1:0] clock_hz,
                                              input logic [ufbs_pkg::BAUD_W-1:0] baud);
    logic [31:0] c, b, m, d, den, num, q, lat, rate, err, best_err;
    divider_t    best;
    c    = 32'(clock_hz);
    b    = 32'(baud);
    best = SLOWEST;
    if (b == 0) begin
      return best;
    end
    q       = c / (32'd16 * b);
    best.dl = q[ufbs_pkg::DL_W-1:0];
    if (c % (32'd16 * b) != 0) begin
      best_err = b;
      for (m = 1; m < 16; m++) begin
        for (d = 0; d < m; d++) begin
          den = b * (d + m);
          num = 2 * m * c;
          // rounding uses a doubled or quadrupled numerator, by headroom
          if (num[31]) begin
            q = ((num / den) / 16 + 1) / 2;
          end else begin
            q = (((4 * m * c) / den) / 32 + 1) / 2;
          end
          lat = q & 32'hFFFF;
          if (lat == 0) begin
            lat = 1;
          end
          if (d > 0 && lat < 2) begin
            lat = 2;
          end
          rate = ((c * m) / (lat * (d + m) * 8) + 1) / 2;
          err  = (rate >= b) ? rate - b : b - rate;
          // strictly better only, so the first best pair wins
          if (err < best_err) begin
            best_err = err;
            best.dl  = lat[ufbs_pkg::DL_W-1:0];
            best.mv  = m[ufbs_pkg::FD_W-1:0];
            best.dav = d[ufbs_pkg::FD_W-1:0];
          end
        end
      end
    end
    return best;
  endfunction

  // random baud rate: mostly of random magnitude, a share that divides the
  // clock exactly (when the clock allows it), and a sprinkling of extremes
  function automatic logic [ufbs_pkg::BAUD_W-1:0] pick_baud(
      input logic [ufbs_pkg::CLK_W-1:0] clock_hz);
    int unsigned sel, w;
    logic [31:0] q, m;
    sel = $urandom_range(99);
    if (sel < 5) begin
      return '1;
    end
    if (sel < 8) begin
      return 24'd1;
    end
    if (sel < 10) begin
      return '0;
    end
    if (sel < 40 && clock_hz != 0 && clock_hz % 16 == 0) begin
      q = 32'(clock_hz) / 32'd16;
      repeat (8) begin
        m = $urandom_range(256, 1);
        if (q % m == 0) begin
          return ufbs_pkg::BAUD_W'(q / m);
        end
      end
    end
    w = $urandom_range(ufbs_pkg::BAUD_W, 1);
    return ufbs_pkg::BAUD_W'($urandom >> (32 - w));
  endfunction

  // lower start and wait until every item sent has produced its result;
  // always lets at least one edge pass so start is not driven twice a step
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_done != items_issued);
  endtask

  // clock register write, only ever with nothing outstanding
  task automatic write_clock(input logic [ufbs_pkg::CLK_W-1:0] hz);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    clock_shadow  = hz;
  endtask

  // offer one item; start stays high after the accepting edge so a
  // following item can go straight on without a dip
  task automatic send_baud(input logic [ufbs_pkg::BAUD_W-1:0] baud, input divider_t want,
                           input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start     <= 1'b1;
    baud_rate <= baud;
    do @(posedge clk); while (busy);
    expected_settings.push_back(want);
    items_issued++;
  endtask

  // result checker and hang watchdog, both sampling just before the edge
  always @(posedge clk) begin
    if (rst) begin
      results_done <= 0;
      quiet_cycles <= 0;
    end else begin
      if (result_valid) begin
        if (expected_settings.size() == 0) begin
          report_mismatch($sformatf("result with no item outstanding: dl %0d mul %0d dadd %0d",
                                    divisor_latch, mul_val, div_add_val));
        end else begin
          oldest_setting = expected_settings.pop_front();
          if (divisor_latch !== oldest_setting.dl) begin
            report_mismatch($sformatf("divisor_latch got %0d expected %0d",
                                      divisor_latch, oldest_setting.dl));
          end
          if (mul_val !== oldest_setting.mv) begin
            report_mismatch($sformatf("mul_val got %0d expected %0d",
                                      mul_val, oldest_setting.mv));
          end
          if (div_add_val !== oldest_setting.dav) begin
            report_mismatch($sformatf("div_add_val got %0d expected %0d",
                                      div_add_val, oldest_setting.dav));
          end
        end
        results_done <= results_done + 1;
      end
      // any handshake counts as progress
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [ufbs_pkg::CLK_W-1:0]  phase_clock [N_PHASES];
    int                          phase_idle  [N_PHASES];
    logic [ufbs_pkg::BAUD_W-1:0] b;
    logic [31:0]                 r;
    divider_t                    want;

    // reset once
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, straight after reset and then across the clock extremes
    for (int i = 0; i < N_ROWS; i++) begin
      if (SETUP_ROWS[i].wr_clock) begin
        write_clock(SETUP_ROWS[i].clock_hz);
      end else begin
        want = SETUP_ROWS[i].typed ? SETUP_ROWS[i].fixed
                                   : search_divider(clock_shadow, SETUP_ROWS[i].baud);
        send_baud(SETUP_ROWS[i].baud, want, 0);
      end
    end

    // random phases: back to the reset clock with no idling, the largest
    // clock with a mostly idle sender, an arbitrary clock at full rate, and
    // a multiple of sixteen (so exact quotients turn up) with light idling
    phase_clock[0] = ufbs_pkg::CLK_RESET;
    phase_clock[1] = '1;
    r              = $urandom;
    phase_clock[2] = r[ufbs_pkg::CLK_W-1:0];
    r              = $urandom;
    phase_clock[3] = {r[ufbs_pkg::CLK_W-5:0], 4'b0000};
    phase_idle[0]  = 0;
    phase_idle[1]  = 79;
    phase_idle[2]  = 0;
    phase_idle[3]  = 8;

    for (int p = 0; p < N_PHASES; p++) begin
      write_clock(phase_clock[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then hold back until the block has gone fully quiet
        if (p == 1 && n % 5 == 4) begin
          wait_drained();
        end
        b = pick_baud(clock_shadow);
        send_baud(b, search_divider(clock_shadow, b), phase_idle[p]);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_settings.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_settings.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ufbs_pkg.sv
rtl/core/uart_fractional_baud_search_unit.sv
tb/sv/uart_fractional_baud_search_unit_test.sv
